>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked implication that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sst_pkg.sv
// types and constants shared by the subresource state tracker modules
package sst_pkg;

   localparam int STATE_W   = 5;
   localparam int LEVEL_W   = 4;
   localparam int LAYER_W   = 4;
   localparam int REQ_W     = 3;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [STATE_W-1:0] STATE_UNKNOWN = 5'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_SET_WHOLE   = 3'd0,
      REQ_SET_SUB     = 3'd1,
      REQ_QUERY_SUB   = 3'd2,
      REQ_MERGE_WHOLE = 3'd3,
      REQ_MERGE_SUB   = 3'd4
   } req_kind_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic rd_entry;
      logic set_whole;
      logic rd_old;
      logic dec_old;
      logic rd_new;
      logic inc_new;
      logic load_rsp;
   } sst_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic whole_go;
      logic sub_go;
      logic rsp_free;
   } sst_status_type;

endpackage

>>> hw/rtl/sst_ctrl.sv
// sequencing state machine of the subresource state tracker
module sst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sst_pkg::sst_status_type status,
   output sst_pkg::sst_cmd_type    cmd
);
   import sst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_OLD_RD,
      ST_DEC,
      ST_NEW_RD,
      ST_INC,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.rd_entry = 1'b1;
            if (status.whole_go) begin
               cmd.set_whole = 1'b1;
               state_in      = ST_FINISH;
            end else if (status.sub_go) begin
               state_in = ST_OLD_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_OLD_RD: begin
            cmd.rd_old = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            cmd.dec_old = 1'b1;
            state_in    = ST_NEW_RD;
         end
         ST_NEW_RD: begin
            cmd.rd_new = 1'b1;
            state_in   = ST_INC;
         end
         ST_INC: begin
            cmd.inc_new = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/sst_dp.sv
// datapath: entry table, occupancy counts, config and response register
module sst_dp #(
   parameter int MAX_LEVELS = 16,
   parameter int MAX_LAYERS = 16,
   parameter int NUM_STATES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sst_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sst_pkg::CFG_W-1:0]           csr_wdata,
   input  sst_pkg::sst_cmd_type                cmd,
   output sst_pkg::sst_status_type             status
);
   import sst_pkg::*;

   localparam int ENTRY_COUNT = MAX_LEVELS * MAX_LAYERS;
   localparam int ENT_AW      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int OCC_DEPTH   = (NUM_STATES < 32) ? NUM_STATES : 32;
   localparam int OCC_AW      = $clog2(OCC_DEPTH);
   localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);
   localparam int GRP_W       = $clog2(OCC_DEPTH + 1);
   localparam int IDX_W       = 12;
   localparam int TOT_W       = 2 * CFG_W;
   localparam int CMP_W       = 16;

   // clamp a written count into one up to the maximum
   function automatic logic [CFG_W-1:0] sat_count(input logic [CFG_W-1:0] v,
                                                  input int hi);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if ({1'b0, v} > (CFG_W+1)'(hi)) begin
         r = CFG_W'(hi);
      end
      return r;
   endfunction

   // latched request fields
   logic [REQ_W-1:0]   req_ff;
   logic [LEVEL_W-1:0] mip_ff;
   logic [LAYER_W-1:0] layer_ff;
   logic [STATE_W-1:0] st_ff;
   logic               did_set_ff;

   // configuration and whole-resource state
   logic [CFG_W-1:0]   level_count_ff;
   logic [CFG_W-1:0]   layer_count_ff;
   logic [STATE_W-1:0] whole_ff;
   logic [GRP_W-1:0]   groups_ff;

   // entry table and its valid bits
   logic [STATE_W-1:0]     ent_mem [ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0] ent_valid_ff;
   logic [STATE_W-1:0]     ent_rd_ff;
   logic                   ent_vrd_ff;

   // occupancy counts and their valid bits
   logic [CNT_W-1:0]     occ_mem [OCC_DEPTH];
   logic [OCC_DEPTH-1:0] occ_valid_ff;
   logic [CNT_W-1:0]     occ_rd_ff;
   logic                 occ_vrd_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic               st_ok;
   logic               addr_ok;
   logic               sub_kind;
   logic [IDX_W-1:0]   idx_wide;
   logic [ENT_AW-1:0]  ent_idx;
   logic [OCC_AW-1:0]  old_idx;
   logic [OCC_AW-1:0]  st_idx;
   logic [OCC_AW-1:0]  occ_raddr;
   logic [OCC_AW-1:0]  occ_waddr;
   logic [CNT_W-1:0]   occ_wdata;
   logic               occ_we;
   logic               dec_ok;
   logic [CNT_W-1:0]   cnt_cur;
   logic [CNT_W-1:0]   cnt_new;
   logic [GRP_W-1:0]   groups_new;
   logic [TOT_W-1:0]   total;
   logic               collapse;
   logic               clear;
   logic [STATE_W-1:0] sub_state;

   // request decode on latched fields
   assign st_ok    = (9'(st_ff) < 9'(NUM_STATES));
   assign addr_ok  = ({1'b0, mip_ff} < level_count_ff) && ({1'b0, layer_ff} < layer_count_ff);
   assign sub_kind = req_ff inside {REQ_SET_SUB, REQ_QUERY_SUB, REQ_MERGE_SUB};
   assign idx_wide = IDX_W'(mip_ff) * IDX_W'(MAX_LAYERS) + IDX_W'(layer_ff);
   assign ent_idx  = idx_wide[ENT_AW-1:0];
   assign old_idx  = ent_rd_ff[OCC_AW-1:0];
   assign st_idx   = st_ff[OCC_AW-1:0];

   assign status.whole_go = st_ok &&
      ((req_ff == REQ_SET_WHOLE) || ((req_ff == REQ_MERGE_WHOLE) && (st_ff != STATE_UNKNOWN)));
   assign status.sub_go = st_ok && addr_ok &&
      ((req_ff == REQ_SET_SUB) || ((req_ff == REQ_MERGE_SUB) && (st_ff != STATE_UNKNOWN))) &&
      !((groups_ff == '0) && (whole_ff == st_ff));
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   // count update arithmetic
   assign dec_ok     = ent_vrd_ff && occ_vrd_ff && (occ_rd_ff != '0);
   assign cnt_cur    = occ_vrd_ff ? occ_rd_ff : '0;
   assign cnt_new    = cnt_cur + CNT_W'(1);
   assign groups_new = groups_ff + GRP_W'(cnt_cur == '0);
   assign total      = TOT_W'(level_count_ff) * TOT_W'(layer_count_ff);
   assign collapse   = (groups_new == GRP_W'(1)) && (CMP_W'(cnt_new) == CMP_W'(total));
   assign clear      = csr_we || cmd.set_whole || (cmd.inc_new && collapse);

   // occupancy memory port control
   assign occ_raddr = cmd.rd_old ? old_idx : st_idx;
   assign occ_waddr = cmd.dec_old ? old_idx : st_idx;
   assign occ_wdata = cmd.dec_old ? (occ_rd_ff - CNT_W'(1)) : cnt_new;
   assign occ_we    = (cmd.dec_old && dec_ok) || (cmd.inc_new && !collapse);

   // latch request fields
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff   <= req_tdata[2:0];
         mip_ff   <= req_tdata[6:3];
         layer_ff <= req_tdata[10:7];
         st_ff    <= req_tdata[15:11];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         did_set_ff     <= 1'b0;
         level_count_ff <= CFG_W'(1);
         layer_count_ff <= CFG_W'(1);
         whole_ff       <= STATE_UNKNOWN;
         groups_ff      <= '0;
         ent_valid_ff   <= '0;
         occ_valid_ff   <= '0;
      end else begin
         if (cmd.load_req) begin
            did_set_ff <= 1'b0;
         end else if (cmd.inc_new) begin
            did_set_ff <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LEVEL_COUNT: level_count_ff <= sat_count(csr_wdata, MAX_LEVELS);
               CSR_LAYER_COUNT: layer_count_ff <= sat_count(csr_wdata, MAX_LAYERS);
               default: ;
            endcase
         end
         if (cmd.set_whole || (cmd.inc_new && collapse)) begin
            whole_ff <= st_ff;
         end
         if (clear) begin
            groups_ff    <= '0;
            ent_valid_ff <= '0;
            occ_valid_ff <= '0;
         end else if (cmd.dec_old && dec_ok && (occ_rd_ff == CNT_W'(1))) begin
            groups_ff <= groups_ff - GRP_W'(1);
         end else if (cmd.inc_new) begin
            groups_ff             <= groups_new;
            ent_valid_ff[ent_idx] <= 1'b1;
            occ_valid_ff[st_idx]  <= 1'b1;
         end
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (cmd.inc_new && !collapse) begin
         ent_mem[ent_idx] <= st_ff;
      end
      if (cmd.rd_entry) begin
         ent_rd_ff  <= ent_mem[ent_idx];
         ent_vrd_ff <= ent_valid_ff[ent_idx];
      end
   end

   // occupancy memory
   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      if (cmd.rd_old || cmd.rd_new) begin
         occ_rd_ff  <= occ_mem[occ_raddr];
         occ_vrd_ff <= occ_valid_ff[occ_raddr];
      end
   end

   // addressed state after the step
   always_comb begin
      sub_state = whole_ff;
      if (sub_kind && addr_ok) begin
         if (did_set_ff) begin
            sub_state = st_ff;
         end else if (ent_vrd_ff) begin
            sub_state = ent_rd_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {5'b0, whole_ff, (groups_ff == '0), sub_state};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/subresource_state_tracker.sv
// top level of the subresource state tracker
// Tracks the usage state of a resource addressed by mip level and array layer: either one
// uniform state or a table of per-subresource entries with per-state occupancy counts that
// fold the table back to a uniform state once every subresource agrees. One request gives
// one response. The block takes one request at a time. A whole-resource set, a query or an
// ignored request goes from decode straight to the finish state, which registers its
// response and returns to idle for the next request. A subresource set or merge first
// passes through the read, decrement, read and increment states, because the occupancy
// counts sit in a memory that is read and written once for the old state and once for the
// new one. A response waiting on rsp_tready holds the finish state until the register
// frees.
// Configuration writes clear the table at once and need no clearing pass.
module subresource_state_tracker #(
   parameter int MAX_LEVELS = 16,
   parameter int MAX_LAYERS = 16,
   parameter int NUM_STATES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: req_type[2:0], mip_level[6:3], array_layer[10:7], new_state[15:11]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sst_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: sub_state[4:0], is_uniform[5], uniform_state[10:6], zero[15:11]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sst_pkg::CFG_W-1:0]      csr_wdata
);
   import sst_pkg::*;

   sst_cmd_type    cmd;
   sst_status_type status;

   // sequencing
   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // tables and response
   sst_dp #(
      .MAX_LEVELS (MAX_LEVELS),
      .MAX_LAYERS (MAX_LAYERS),
      .NUM_STATES (NUM_STATES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> hw/rtl/sst_checker.sv
// port-level checks of the subresource state tracker and their bind
`include "assert_macros.svh"

module sst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_we,
   input logic [0:0]  csr_index,
   input logic [4:0]  csr_wdata
);

   // a stalled response keeps its contents
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // one request at a time: busy right after a request is taken
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

   // a uniform resource reports the uniform state for any subresource
   `ASSERT_CLK(a_uniform_sub, clock, reset, rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[4:0] == rsp_tdata[10:6], "uniform response with differing state")

endmodule

bind subresource_state_tracker sst_checker u_sst_checker (.*);

>>> tb/subresource_state_tracker_checker.sv
// request/response checker with its own state prediction for the subresource state tracker
module subresource_state_tracker_checker #(
   parameter int MAX_LEVELS = 16,
   parameter int MAX_LAYERS = 16,
   parameter int NUM_STATES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [sst_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sst_pkg::CFG_W-1:0]      csr_wdata,
   output int                             error_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             fold_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sst_pkg::*;

   localparam int ENTRY_COUNT = MAX_LEVELS * MAX_LAYERS;
   localparam int PRINT_CAP   = 100;

   // request word, lowest field last
   typedef struct packed {
      logic [STATE_W-1:0] new_state;
      logic [LAYER_W-1:0] layer;
      logic [LEVEL_W-1:0] mip;
      logic [REQ_W-1:0]   kind;
   } req_word_type;

   // response word, lowest field last
   typedef struct packed {
      logic [RSP_DATA_W-2*STATE_W-2:0] pad;
      logic [STATE_W-1:0]              whole;
      logic                            uniform;
      logic [STATE_W-1:0]              sub;
   } rsp_word_type;

   // predicted tracker state
   logic [STATE_W-1:0] whole_st;
   bit                 has_entry [ENTRY_COUNT];
   logic [STATE_W-1:0] entry_st [ENTRY_COUNT];
   int unsigned        occ_count [NUM_STATES];
   int unsigned        live_states;
   int unsigned        num_levels;
   int unsigned        num_layers;

   rsp_word_type expected_q[$];

   function automatic void clear_entries();
      foreach (has_entry[i]) has_entry[i] = 1'b0;
      foreach (occ_count[i]) occ_count[i] = 0;
      live_states = 0;
   endfunction

   function automatic int unsigned clamp_extent(logic [CFG_W-1:0] raw, int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic bit addr_in_range(logic [LEVEL_W-1:0] mip, logic [LAYER_W-1:0] layer);
      return (mip < num_levels) && (layer < num_layers);
   endfunction

   function automatic void load_whole(logic [STATE_W-1:0] st);
      clear_entries();
      whole_st = st;
   endfunction

   // one subresource write with occupancy bookkeeping and fold-back
   function automatic void write_sub(int unsigned idx, logic [STATE_W-1:0] st);
      logic [STATE_W-1:0] prior;
      if (live_states == 0 && whole_st == st) return;
      if (has_entry[idx]) begin
         prior = entry_st[idx];
         if (occ_count[prior] > 0) begin
            occ_count[prior]--;
            if (occ_count[prior] == 0) live_states--;
         end
      end
      has_entry[idx] = 1'b1;
      entry_st[idx]  = st;
      if (occ_count[st] == 0) live_states++;
      occ_count[st]++;
      // every subresource agrees: back to one uniform state
      if (live_states == 1 && occ_count[st] == num_levels * num_layers) begin
         load_whole(st);
         fold_count++;
      end
   endfunction

   // apply one request and work out its response
   function automatic rsp_word_type apply_request(req_word_type rq);
      rsp_word_type r;
      int unsigned  idx;
      bit           hit;
      bit           st_ok;
      idx   = rq.mip * MAX_LAYERS + rq.layer;
      hit   = addr_in_range(rq.mip, rq.layer);
      // state codes past the last one are ignored
      st_ok = (rq.new_state < NUM_STATES);
      case (rq.kind)
         REQ_SET_WHOLE: begin
            if (st_ok) load_whole(rq.new_state);
         end
         REQ_SET_SUB: begin
            if (st_ok && hit) write_sub(idx, rq.new_state);
         end
         REQ_MERGE_WHOLE: begin
            if (st_ok && rq.new_state != STATE_UNKNOWN) load_whole(rq.new_state);
         end
         REQ_MERGE_SUB: begin
            if (st_ok && hit && rq.new_state != STATE_UNKNOWN) write_sub(idx, rq.new_state);
         end
         default: ;
      endcase
      r         = '0;
      r.whole   = whole_st;
      r.uniform = (live_states == 0);
      r.sub     = whole_st;
      if ((rq.kind == REQ_SET_SUB || rq.kind == REQ_QUERY_SUB || rq.kind == REQ_MERGE_SUB)
          && hit && has_entry[idx]) begin
         r.sub = entry_st[idx];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < PRINT_CAP) begin
         $display("%0t: response %0d, %s: got %0d, expected %0d",
                  $time, checked_count, what, got, want);
      end
      error_count++;
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         whole_st   = STATE_UNKNOWN;
         num_levels = 1;
         num_layers = 1;
         clear_entries();
         expected_q.delete();
         error_count   = 0;
         checked_count = 0;
         fold_count    = 0;
      end else begin
         // register write clears the table, keeps the uniform state
         if (csr_we) begin
            if (csr_index == CSR_LEVEL_COUNT)
               num_levels = clamp_extent(csr_wdata, MAX_LEVELS);
            else if (csr_index == CSR_LAYER_COUNT)
               num_layers = clamp_extent(csr_wdata, MAX_LAYERS);
            clear_entries();
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(apply_request(req_word_type'(req_tdata)));
         // compare against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (expected_q.size() == 0) begin
               report_mismatch("response with no request waiting, tdata", got, 0);
            end else begin
               want = expected_q.pop_front();
               if (got.sub !== want.sub) report_mismatch("sub_state", got.sub, want.sub);
               if (got.uniform !== want.uniform)
                  report_mismatch("is_uniform", got.uniform, want.uniform);
               if (got.whole !== want.whole)
                  report_mismatch("uniform_state", got.whole, want.whole);
               if (got.pad !== want.pad) report_mismatch("zero fill", got.pad, want.pad);
               checked_count++;
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

>>> tb/subresource_state_tracker_tb.sv
// testbench top: clock, reset, request and response traffic and verdict for the state tracker
module subresource_state_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sst_pkg::*;

   localparam int MAX_LEVELS    = 16;
   localparam int MAX_LAYERS    = 16;
   localparam int NUM_STATES    = 32;
   localparam int HOLD_CYCLES   = 80;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_TARGET = 900;
   localparam int CALM_AFTER    = 760;
   localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = CSR_LEVEL_COUNT;
   logic [CFG_W-1:0]        csr_wdata  = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int fold_count;

   bit                 req_idle_en = 1'b0;
   bit                 rsp_idle_en = 1'b0;
   bit                 hold_rsp    = 1'b0;
   int unsigned        cur_levels  = 1;
   int unsigned        cur_layers  = 1;
   int                 sent_useful = 0;
   int                 config_writes = 0;
   int                 holds_done  = 0;
   int                 quiet_cycles = 0;
   logic [STATE_W-1:0] pool [3];

   subresource_state_tracker #(
      .MAX_LEVELS (MAX_LEVELS),
      .MAX_LAYERS (MAX_LAYERS),
      .NUM_STATES (NUM_STATES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   subresource_state_tracker_checker #(
      .MAX_LEVELS (MAX_LEVELS),
      .MAX_LAYERS (MAX_LAYERS),
      .NUM_STATES (NUM_STATES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .fold_count    (fold_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // offer one request and hold it until accepted, then maybe pause
   task automatic push_request(input logic [REQ_W-1:0] kind, input logic [LEVEL_W-1:0] mip,
                               input logic [LAYER_W-1:0] layer, input logic [STATE_W-1:0] st);
      req_tdata  <= {st, layer, mip, kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_SET_WHOLE || kind == REQ_MERGE_WHOLE || kind == REQ_QUERY_SUB
          || ((kind == REQ_SET_SUB || kind == REQ_MERGE_SUB)
              && mip < cur_levels && layer < cur_layers)) begin
         sent_useful++;
      end
      if (req_idle_en && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // stop offering and let every expected response arrive
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write both extent registers back to back while idle
   task automatic write_geometry(input logic [CFG_W-1:0] raw_levels,
                                 input logic [CFG_W-1:0] raw_layers);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_LEVEL_COUNT;
      csr_wdata <= raw_levels;
      @(posedge clock);
      csr_index <= CSR_LAYER_COUNT;
      csr_wdata <= raw_layers;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_levels = (raw_levels == 0) ? 1 : (raw_levels > MAX_LEVELS) ? MAX_LEVELS : raw_levels;
      cur_layers = (raw_layers == 0) ? 1 : (raw_layers > MAX_LAYERS) ? MAX_LAYERS : raw_layers;
      config_writes += 2;
   endtask

   // mostly small extents, sometimes the saturating extremes
   function automatic logic [CFG_W-1:0] pick_extent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CFG_W'(MAX_LEVELS);
         2: return CFG_W'($urandom_range(17, 31));
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   // one request of any kind, mostly in range and from the phase state pool
   task automatic random_item();
      logic [REQ_W-1:0]   kind;
      logic [LEVEL_W-1:0] mip;
      logic [LAYER_W-1:0] layer;
      logic [STATE_W-1:0] st;
      int unsigned        roll;
      roll = $urandom_range(0, 99);
      if (roll < 6)       kind = REQ_SET_WHOLE;
      else if (roll < 36) kind = REQ_SET_SUB;
      else if (roll < 56) kind = REQ_QUERY_SUB;
      else if (roll < 62) kind = REQ_MERGE_WHOLE;
      else if (roll < 94) kind = REQ_MERGE_SUB;
      else                kind = REQ_W'($urandom_range(REQ_MERGE_SUB + 1, REQ_CODE_MAX));
      mip   = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom) :
              LEVEL_W'($urandom_range(0, cur_levels - 1));
      layer = ($urandom_range(0, 9) == 0) ? LAYER_W'($urandom) :
              LAYER_W'($urandom_range(0, cur_layers - 1));
      st    = ($urandom_range(0, 4) == 0) ? STATE_W'($urandom) : pool[$urandom_range(0, 2)];
      push_request(kind, mip, layer, st);
   endtask

   // visit every subresource once in shuffled order with one state, with occasional queries and random requests between
   task automatic fill_run(input logic [STATE_W-1:0] st);
      int unsigned      spots[$];
      int unsigned      j;
      int unsigned      tmp;
      logic [REQ_W-1:0] kind;
      for (int m = 0; m < cur_levels; m++)
         for (int l = 0; l < cur_layers; l++) spots.push_back(m * MAX_LAYERS + l);
      for (int i = spots.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = spots[i];
         spots[i] = spots[j];
         spots[j] = tmp;
      end
      foreach (spots[i]) begin
         kind = ($urandom_range(0, 1) != 0) ? REQ_SET_SUB : REQ_MERGE_SUB;
         push_request(kind, LEVEL_W'(spots[i] / MAX_LAYERS), LAYER_W'(spots[i] % MAX_LAYERS), st);
         if ($urandom_range(0, 6) == 0) begin
            push_request(REQ_QUERY_SUB, LEVEL_W'($urandom_range(0, cur_levels - 1)),
                         LAYER_W'($urandom_range(0, cur_layers - 1)), STATE_W'($urandom));
         end
         if ($urandom_range(0, 19) == 0) random_item();
      end
   endtask

   // response side: random stall bursts and the requested long hold
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_rsp) begin
            hold_rsp   = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            holds_done++;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin : stim
      int phase;
      int quota;
      bit calm;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single subresource after reset
      push_request(REQ_QUERY_SUB, 4'd0, 4'd0, STATE_UNKNOWN);
      push_request(REQ_SET_SUB, 4'd0, 4'd0, STATE_UNKNOWN);   // matches uniform state
      push_request(REQ_SET_SUB, 4'd0, 4'd0, 5'd5);            // folds back at once
      push_request(REQ_MERGE_WHOLE, 4'd0, 4'd0, STATE_UNKNOWN);
      push_request(REQ_MERGE_WHOLE, 4'd0, 4'd0, 5'd31);
      push_request(REQ_MERGE_SUB, 4'd0, 4'd0, STATE_UNKNOWN);
      push_request(REQ_SET_SUB, 4'd15, 4'd15, 5'd3);          // address out of range
      push_request(REQ_CODE_MAX, 4'd15, 4'd15, 5'd31);        // undefined kind

      // directed: 2x2 table, split, reassign, fold
      write_geometry(5'd2, 5'd2);
      push_request(REQ_SET_SUB, 4'd0, 4'd0, 5'd1);
      push_request(REQ_SET_SUB, 4'd0, 4'd1, 5'd2);
      push_request(REQ_QUERY_SUB, 4'd1, 4'd1, 5'd0);          // unset entry reads whole
      push_request(REQ_QUERY_SUB, 4'd0, 4'd1, 5'd0);
      push_request(REQ_MERGE_SUB, 4'd1, 4'd0, 5'd1);
      push_request(REQ_SET_SUB, 4'd0, 4'd1, 5'd1);
      push_request(REQ_MERGE_SUB, 4'd1, 4'd1, 5'd1);          // all agree
      push_request(REQ_SET_SUB, 4'd1, 4'd1, 5'd3);
      push_request(REQ_SET_WHOLE, 4'd0, 4'd0, STATE_UNKNOWN);
      push_request(REQ_W'(REQ_MERGE_SUB + 1), 4'd1, 4'd1, 5'd7);

      // directed: saturating register values, one level by sixteen layers
      write_geometry(5'd0, 5'd31);
      push_request(REQ_SET_SUB, 4'd0, 4'd15, 5'd31);
      push_request(REQ_QUERY_SUB, 4'd0, 4'd15, 5'd0);
      push_request(REQ_QUERY_SUB, 4'd1, 4'd0, 5'd0);
      push_request(REQ_MERGE_SUB, 4'd0, 4'd15, STATE_UNKNOWN);

      // directed: full size
      write_geometry(5'd16, 5'd16);
      push_request(REQ_SET_SUB, 4'd15, 4'd15, 5'd17);
      push_request(REQ_QUERY_SUB, 4'd15, 4'd15, 5'd0);
      push_request(REQ_SET_WHOLE, 4'd0, 4'd0, 5'd10);

      // random phases, each under its own geometry and state pool
      sent_useful = 0;
      phase       = 0;
      while (sent_useful < RANDOM_TARGET) begin
         if (phase == 0) write_geometry(5'd16, 5'd16);
         else            write_geometry(pick_extent(), pick_extent());
         foreach (pool[k]) pool[k] = STATE_W'($urandom);
         calm        = (sent_useful >= CALM_AFTER);
         req_idle_en = !calm && ($urandom_range(0, 3) != 0);
         rsp_idle_en = !calm && ($urandom_range(0, 3) != 0);
         if (phase == 2 || phase == 5) hold_rsp = 1'b1;
         quota = sent_useful + $urandom_range(40, 80);
         if (phase == 0) fill_run(pool[0]);
         while (sent_useful < quota) begin
            if ($urandom_range(0, 9) < 5) fill_run(pool[$urandom_range(0, 2)]);
            else repeat ($urandom_range(1, 6)) random_item();
         end
         phase++;
      end

      settle();
      $display("run covered %0d random requests over %0d geometry settings, %0d responses checked",
               sent_useful, phase, checked_count);
      $display("%0d register writes, %0d predicted fold-backs to a uniform state, %0d long holds",
               config_writes, fold_count, holds_done);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
